@@ hw/rtl/dsu_pkg.sv @@
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared constants, codes and controller/datapath bundles of the union-find
// block.
// ----------------------------------------------------------------------------
package dsu_pkg;

  localparam int unsigned Nodes = 1024;
  localparam int unsigned NodeW = 10;
  localparam int unsigned OpW   = 2;
  localparam int unsigned IdxW  = $clog2(Nodes);

  localparam logic [NodeW:0] NodesExt = (NodeW + 1)'(Nodes);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Nodes - 1);

  typedef enum logic [OpW-1:0] {
    OP_FIND  = 2'd0,
    OP_UNION = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_START,
    ST_WALK,
    ST_COMPRESS,
    ST_FIN,
    ST_LINK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;      // capture the input word
    logic start;     // begin a walk at the current target
    logic step;      // follow the parent just read
    logic set_root;  // the current node is the root
    logic root_tgt;  // target has no entry, it is its own root
    logic wr_path;   // point the current node at the root
    logic fin;       // commit the root to root_a or root_b
    logic sel_b;     // next find works on node_b
    logic link;      // point root_a at root_b
    logic clr;       // write one entry of the clearing sweep
    logic push;      // load the output register
  } dsu_cmd_t;

  typedef struct packed {
    logic [OpW-1:0] in_op;
    logic           tgt_in_range;
    logic           parent_is_self;
    logic           tgt_is_cur;
    logic           path_end;
    logic           is_sel_b;
    logic [OpW-1:0] op;
    logic           link_ok;
    logic           clr_last;
    logic           out_free;
  } dsu_status_t;

endpackage

@@ hw/rtl/dsu_if.sv @@
// ----------------------------------------------------------------------------
// dsu_req_if / dsu_rsp_if
// Valid/ready channels that carry request and result words of the
// union-find block.
// ----------------------------------------------------------------------------
interface dsu_req_if;
  import dsu_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [NodeW-1:0] node_a;
  logic [NodeW-1:0] node_b;

  modport source (output valid, output operation, output node_a, output node_b,
                  input ready);
  modport sink (input valid, input operation, input node_a, input node_b,
                output ready);
endinterface

interface dsu_rsp_if;
  import dsu_pkg::*;

  logic             valid;
  logic             ready;
  logic [NodeW-1:0] root_a;
  logic [NodeW-1:0] root_b;

  modport source (output valid, output root_a, output root_b, input ready);
  modport sink (input valid, input root_a, input root_b, output ready);
endinterface

@@ hw/rtl/dsu_datapath.sv @@
// ----------------------------------------------------------------------------
// dsu_datapath
// Parent table memory, walk registers and output register of the union-find
// block, driven by commands from the controller.
// ----------------------------------------------------------------------------
module dsu_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [dsu_pkg::OpW-1:0]   operation_i,
  input  logic [dsu_pkg::NodeW-1:0] node_a_i,
  input  logic [dsu_pkg::NodeW-1:0] node_b_i,
  input  dsu_pkg::dsu_cmd_t         cmd_i,
  output dsu_pkg::dsu_status_t      status_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [dsu_pkg::NodeW-1:0] root_a_o,
  output logic [dsu_pkg::NodeW-1:0] root_b_o
);
  import dsu_pkg::*;

  logic [IdxW-1:0]  mem [Nodes];
  logic [IdxW-1:0]  rdata_q;
  logic [IdxW-1:0]  rd_addr;
  logic             we;
  logic [IdxW-1:0]  waddr;
  logic [IdxW-1:0]  wdata;

  logic [OpW-1:0]   op_q;
  logic [NodeW-1:0] a_q, b_q, cur_q, cur_d, root_q, ra_q, rb_q;
  logic [NodeW-1:0] out_ra_q, out_rb_q;
  logic             sel_b_q, out_valid_q;
  logic [IdxW-1:0]  clr_cnt_q;

  logic [NodeW-1:0] tgt;
  logic [NodeW-1:0] parent;

  assign tgt    = sel_b_q ? b_q : a_q;
  assign parent = NodeW'(rdata_q);

  // A walk either starts at the target or follows the parent just read.
  assign cur_d   = cmd_i.start ? tgt : parent;
  assign rd_addr = IdxW'(cur_d);

  always_comb begin
    we    = 1'b1;
    waddr = IdxW'(cur_q);
    wdata = IdxW'(root_q);
    priority if (cmd_i.clr) begin
      waddr = clr_cnt_q;
      wdata = clr_cnt_q;
    end else if (cmd_i.link) begin
      waddr = IdxW'(ra_q);
      wdata = IdxW'(rb_q);
    end else begin
      we = cmd_i.wr_path;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_b_q     <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        sel_b_q <= 1'b0;
      end else if (cmd_i.sel_b) begin
        sel_b_q <= 1'b1;
      end
      if (cmd_i.clr) begin
        clr_cnt_q <= (clr_cnt_q == LastIdx) ? '0 : clr_cnt_q + 1'b1;
      end
      out_valid_q <= cmd_i.push | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i;
      a_q  <= node_a_i;
      b_q  <= node_b_i;
      ra_q <= '0;
      rb_q <= '0;
    end
    if (cmd_i.start || cmd_i.step) begin
      cur_q <= cur_d;
    end
    if (cmd_i.set_root) begin
      root_q <= cur_q;
    end else if (cmd_i.root_tgt) begin
      root_q <= tgt;
    end
    if (cmd_i.fin) begin
      if (sel_b_q) begin
        rb_q <= root_q;
      end else begin
        ra_q <= root_q;
      end
    end
    if (cmd_i.push) begin
      out_ra_q <= ra_q;
      out_rb_q <= rb_q;
    end
  end

  always_comb begin
    status_o.in_op          = operation_i;
    status_o.tgt_in_range   = {1'b0, tgt} < NodesExt;
    status_o.parent_is_self = parent == cur_q;
    status_o.tgt_is_cur     = tgt == cur_q;
    status_o.path_end       = parent == root_q;
    status_o.is_sel_b       = sel_b_q;
    status_o.op             = op_q;
    status_o.link_ok        = ({1'b0, ra_q} < NodesExt) && ({1'b0, rb_q} < NodesExt);
    status_o.clr_last       = clr_cnt_q == LastIdx;
    status_o.out_free       = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign root_a_o    = out_ra_q;
  assign root_b_o    = out_rb_q;

endmodule

@@ hw/rtl/dsu_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsu_ctrl
// Controller of the union-find block: sequences the clearing sweep, the
// passes of each find, the root link of a union and the result hand-off.
// ----------------------------------------------------------------------------
module dsu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dsu_pkg::dsu_status_t status_i,
  output dsu_pkg::dsu_cmd_t    cmd_o
);
  import dsu_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_DONE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_op == OP_FIND || status_i.in_op == OP_UNION) begin
            state_d = ST_START;
          end else if (status_i.in_op == OP_CLEAR) begin
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_START: begin
        state_d = status_i.tgt_in_range ? ST_WALK : ST_FIN;
      end
      ST_WALK: begin
        if (status_i.parent_is_self) begin
          state_d = status_i.tgt_is_cur ? ST_FIN : ST_COMPRESS;
        end
      end
      ST_COMPRESS: begin
        if (status_i.path_end) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!status_i.is_sel_b && status_i.op == OP_UNION) begin
          state_d = ST_START;
        end else if (status_i.is_sel_b) begin
          state_d = ST_LINK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_LINK: state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT, ST_CLEAR: cmd_o.clr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_START: begin
        if (status_i.tgt_in_range) begin
          cmd_o.start = 1'b1;
        end else begin
          cmd_o.root_tgt = 1'b1;
        end
      end
      ST_WALK: begin
        if (status_i.parent_is_self) begin
          cmd_o.set_root = 1'b1;
          // Second pass restarts at the target unless it is the root itself.
          cmd_o.start    = ~status_i.tgt_is_cur;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_COMPRESS: begin
        cmd_o.wr_path = 1'b1;
        cmd_o.step    = ~status_i.path_end;
      end
      ST_FIN: begin
        cmd_o.fin   = 1'b1;
        cmd_o.sel_b = ~status_i.is_sel_b && status_i.op == OP_UNION;
      end
      ST_LINK: cmd_o.link = status_i.link_ok;
      ST_DONE: cmd_o.push = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ hw/rtl/disjoint_set_union_find.sv @@
// ----------------------------------------------------------------------------
// disjoint_set_union_find
// Union-find over a 1024-entry parent table with full path compression.
//
// A request word on in_i carries operation, node_a and node_b; each request
// yields exactly one result word (root_a, root_b) on out_o. Both channels
// move a word when valid and ready are high at a rising edge.
// A find walks the parent chain from node_a to its root with one table
// read per step on the single memory read port, then one rewrite per step
// of the path. A union runs two finds plus a link of the roots. A clear
// sweeps the table one entry per cycle before it presents its result.
// The next request is taken only after a result is pushed, since one
// request is processed at a time; in_i.ready is high only while idle.
// After reset the same sweep fills the table before the first request is
// taken. The result sits in an output register, so the next request is
// taken while an earlier result waits; if out_o stays stalled, the
// following result holds the block until that register frees up.
// ----------------------------------------------------------------------------
module disjoint_set_union_find (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsu_req_if.sink   in_i,
  dsu_rsp_if.source out_o
);
  import dsu_pkg::*;

  dsu_cmd_t    cmd;
  dsu_status_t status;

  dsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dsu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operation_i (in_i.operation),
    .node_a_i    (in_i.node_a),
    .node_b_i    (in_i.node_b),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .root_a_o    (out_o.root_a),
    .root_b_o    (out_o.root_b)
  );

  // Only one source may drive the table write port in a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr, cmd.wr_path, cmd.link}))
    else $error("parent table write port driven by two sources");

  // A result never overwrites a word that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!out_o.valid || out_o.ready))
    else $error("result pushed over an undelivered word");

  // A pushed result shows up on the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |=> out_o.valid)
    else $error("pushed result not presented");

  // A walk starts or steps, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.step}))
    else $error("walk start and step together");

endmodule
